// ----- sv/wsp_pkg.sv -----
// Shared types and constants for the WAVE stream parser.
`default_nettype none

package wsp_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 3;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
    localparam logic [2:0] ST_NOT_PCM   = 3'd3;
    localparam logic [2:0] ST_BAD_FMT   = 3'd4;
    localparam logic [2:0] ST_NO_FMT    = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    localparam logic [15:0] PCM_KIND = 16'd1;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_DROP = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  idx;
        logic [31:0] shift;
        logic [31:0] tag;
        logic [31:0] left;
        logic [15:0] kind;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] bits;
        logic        fmt_seen;
    } parse_state_t;

    typedef struct packed {
        logic        have;
        logic        dv;
        logic        df;
        logic        done;
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic [1:0]  chans;
        logic [31:0] rate;
        logic [4:0]  bits;
    } parse_result_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:    PH_RIFF,
        idx:      5'd0,
        shift:    32'd0,
        tag:      32'd0,
        left:     32'd0,
        kind:     16'd0,
        chans:    16'd0,
        rate:     32'd0,
        bits:     16'd0,
        fmt_seen: 1'b0
    };

endpackage

`default_nettype wire

// ----- sv/wsp_step.sv -----
// Per-byte parse step: next parser state and the result for one input byte.
`default_nettype none

module wsp_step (
    input  wire wsp_pkg::parse_state_t  cur,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    output wsp_pkg::parse_state_t       nxt,
    output wsp_pkg::parse_result_t      res
);
    import wsp_pkg::*;

    logic [31:0]  shift_new;
    logic [31:0]  left_dec;
    logic [15:0]  bits_new;
    logic [2:0]   err;
    logic         chan_ok;
    logic         bits_ok;
    parse_state_t post;

    assign shift_new = {in_byte, cur.shift[31:8]};
    assign left_dec  = cur.left - 32'd1;
    assign bits_new  = shift_new[31:16];
    assign chan_ok   = (cur.chans == 16'd1) || (cur.chans == 16'd2);
    assign bits_ok   = (bits_new == 16'd8) || (bits_new == 16'd16);

    // error detection on header tags and the format body
    always_comb begin
        err = ST_OK;
        unique case (cur.phase)
            PH_RIFF: begin
                if (cur.idx == 5'd3 && shift_new != TAG_RIFF) begin
                    err = ST_NOT_RIFF;
                end else if (cur.idx == 5'd11 && shift_new != TAG_WAVE) begin
                    err = ST_NOT_WAVE;
                end
            end
            PH_FMT: begin
                if (cur.idx == 5'd15) begin
                    if (cur.kind != PCM_KIND) begin
                        err = ST_NOT_PCM;
                    end else if (!chan_ok || !bits_ok) begin
                        err = ST_BAD_FMT;
                    end
                end
            end
            default: err = ST_OK;
        endcase
    end

    // next state
    always_comb begin
        post = cur;
        if (cur.phase != PH_DROP) begin
            post.shift = shift_new;
        end
        unique case (cur.phase)
            PH_RIFF: begin
                if (cur.idx == 5'd11 && err == ST_OK) begin
                    post.phase = PH_HDR;
                    post.idx   = 5'd0;
                end else begin
                    post.idx = cur.idx + 5'd1;
                end
            end
            PH_HDR: begin
                if (cur.idx == 5'd3) begin
                    post.tag = shift_new;
                end
                if (cur.idx == 5'd7) begin
                    post.left = shift_new;
                    post.idx  = 5'd0;
                    if (cur.tag == TAG_FMT) begin
                        post.phase = PH_FMT;
                    end else if (shift_new == 32'd0) begin
                        post.phase = PH_HDR;
                    end else if (cur.tag == TAG_DATA) begin
                        post.phase = PH_DATA;
                    end else begin
                        post.phase = PH_SKIP;
                    end
                end else begin
                    post.idx = cur.idx + 5'd1;
                end
            end
            PH_FMT: begin
                if (cur.idx == 5'd1) begin
                    post.kind = shift_new[31:16];
                end
                if (cur.idx == 5'd3) begin
                    post.chans = shift_new[31:16];
                end
                if (cur.idx == 5'd7) begin
                    post.rate = shift_new;
                end
                if (cur.idx == 5'd15) begin
                    post.bits = bits_new;
                    if (err == ST_OK) begin
                        post.fmt_seen = 1'b1;
                        post.idx      = 5'd0;
                        // extra format bytes beyond the 16-byte body are skipped
                        if (cur.left > 32'd16) begin
                            post.left  = cur.left - 32'd16;
                            post.phase = PH_SKIP;
                        end else begin
                            post.left  = 32'd0;
                            post.phase = PH_HDR;
                        end
                    end
                end else begin
                    post.idx = cur.idx + 5'd1;
                end
            end
            PH_SKIP: begin
                post.left = left_dec;
                if (left_dec == 32'd0) begin
                    post.phase = PH_HDR;
                    post.idx   = 5'd0;
                end
            end
            PH_DATA: begin
                post.left = left_dec;
                post.idx  = 5'd1;
                if (left_dec == 32'd0) begin
                    post.phase = PH_HDR;
                    post.idx   = 5'd0;
                end
            end
            default: begin
            end
        endcase
        if (err != ST_OK) begin
            post.phase = PH_DROP;
        end
    end

    // the last byte of a file always rearms the parser
    assign nxt = in_last ? PARSE_RESET : post;

    // result fields
    always_comb begin
        res        = '0;
        res.dv     = (cur.phase == PH_DATA);
        res.df     = (cur.phase == PH_DATA) && (cur.idx == 5'd0);
        res.done   = (err != ST_OK) || (in_last && cur.phase != PH_DROP);
        if (err != ST_OK) begin
            res.status = err;
        end else if (in_last && cur.phase != PH_DROP) begin
            if (post.phase == PH_HDR && post.idx == 5'd0) begin
                res.status = post.fmt_seen ? ST_OK : ST_NO_FMT;
            end else begin
                res.status = ST_TRUNCATED;
            end
        end else begin
            res.status = ST_OK;
        end
        res.data_byte = res.dv ? in_byte : 8'd0;
        if (res.done && res.status == ST_OK) begin
            res.chans = post.chans[1:0];
            res.rate  = post.rate;
            res.bits  = post.bits[4:0];
        end
        res.have = res.dv || res.done;
    end

endmodule

`default_nettype wire

// ----- sv/wave_stream_parser.sv -----
// WAVE stream parser top level: parser state, output register and handshake.
//
// Input: one byte of a RIFF WAVE file per transfer on s_axis, s_axis_tlast on the
// final byte of the file. Output: zero or one transfer per input byte on m_axis:
// a payload byte from a data chunk (tuser bit 0, bit 1 on the first byte of each
// data chunk), and/or a completion report (tuser bit 2) carrying the status and,
// for status ok, the channel count, sample rate and bits per sample.
// An input transfer's result is in the output register in the next cycle.
// Throughput is one byte per cycle while m_axis is not stalled: the whole parse
// step is one level of compares and 32-bit counter updates between the state
// registers and the output register.
// s_axis_tready is high whenever the output register is empty or being drained
// in the same cycle, so a stall on m_axis holds the pending result and stops
// input only while it lasts.
// After an error the rest of the file is dropped without results; the last byte
// of any file rearms the parser for the next file.
// Reset (aresetn low, synchronous) empties the output register and returns the
// parser to the start of a file with no format held.
`default_nettype none

module wave_stream_parser (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] in_byte
    input  wire logic [wsp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] data_byte, [10:8] status, [12:11] channel_count,
    // [44:13] sample_rate, [49:45] sample_bits, [55:50] zero
    output logic [wsp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // [0] data_valid, [1] data_first, [2] done_res
    output logic [wsp_pkg::OUT_TUSER_W-1:0]        m_axis_tuser
);
    import wsp_pkg::*;

    parse_state_t               state_reg;
    parse_state_t               state_next;
    parse_result_t              res;
    logic                       accept;
    logic                       m_tvalid_reg;
    logic                       m_tvalid_next;
    logic [OUT_TDATA_W-1:0]     m_tdata_reg;
    logic [OUT_TDATA_W-1:0]     m_tdata_next;
    logic [OUT_TUSER_W-1:0]     m_tuser_reg;
    logic [OUT_TUSER_W-1:0]     m_tuser_next;

    wsp_step u_step (
        .cur     (state_reg),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .nxt     (state_next),
        .res     (res)
    );

    assign s_axis_tready = !m_tvalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept) begin
            m_tvalid_next = res.have;
            m_tdata_next  = {6'd0, res.bits, res.rate, res.chans, res.status, res.data_byte};
            m_tuser_next  = {res.done, res.df, res.dv};
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= PARSE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- sv/wsp_checker.sv -----
// Port-level checks for the WAVE stream parser, bound to the top level.
`default_nettype none

module wsp_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [wsp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [wsp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import wsp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // first mark only on a payload byte
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("first mark without payload");

    // format fields only in a successful completion report
    a_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (!m_axis_tuser[2] || m_axis_tdata[10:8] != ST_OK)
            |-> m_axis_tdata[49:11] == 39'd0)
        else $error("format fields outside an ok report");

    // an empty output register never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind wave_stream_parser wsp_checker u_wsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
